[src/wall_column_texture_mapper_assert.svh]
// Assertion macros for the wall column texture mapper.
`ifndef WALL_COLUMN_TEXTURE_MAPPER_ASSERT_SVH
`define WALL_COLUMN_TEXTURE_MAPPER_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, disabled in reset.
`define WCTM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wctm: implication check failed");
// Next-cycle implication, sampled on clk, disabled in reset.
`define WCTM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wctm: next-cycle check failed");
`else
`define WCTM_ASSERT_IMP(lbl, ante, cons)
`define WCTM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[src/wctm_pkg.sv]
// Shared types, codes and constants of the wall column texture mapper.
`timescale 1ns / 1ps
package wctm_pkg;

  localparam int SCREEN_ROWS_DEF     = 480;
  localparam int TEXTURE_COLUMNS_DEF = 64;
  localparam int TEXTURE_ROWS_DEF    = 64;

  // Field widths of the streams
  localparam int COL_W  = 10;
  localparam int DIST_W = 24;
  localparam int DIR_W  = 18;
  localparam int POS_W  = 24;
  localparam int ROW_W  = 9;
  localparam int TEX_W  = 6;
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 56;

  localparam logic FUNC_SETUP = 1'b0;
  localparam logic FUNC_STEP  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SETUP = 2'd0,
    KIND_PIXEL = 2'd1,
    KIND_IDLE  = 2'd2
  } kind_t;

  typedef enum logic {
    DIV_HEIGHT = 1'b0,
    DIV_INCR   = 1'b1
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     step;
    logic     div_start;
    div_sel_t div_sel;
    logic     h_load;
    logic     span;
    logic     inc_load;
    logic     commit;
  } wctm_cmd_t;

  typedef struct packed {
    logic div_done;
  } wctm_sts_t;

  typedef struct packed {
    kind_t              kind;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
    logic [TEX_W-1:0]   tex_col;
    logic [TEX_W-1:0]   tex_row;
    logic [ROW_W-1:0]   span_top;
    logic [ROW_W-1:0]   span_bottom;
    logic               last;
  } wctm_result_t;

endpackage

[src/wctm_divider.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module wctm_divider #(
  parameter int W = 25
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CNT_W = $clog2(W);

  logic [W-1:0]     rem_r, quo_r, divs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r, done_r;
  logic [W:0]       shifted, diff;
  logic             ge;

  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, divs_r};
  assign ge      = !diff[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      quo_r  <= dividend;
      divs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[W-1:0] : shifted[W-1:0];
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

[src/wctm_datapath.sv]
// Datapath: slice geometry, texture mapping and per-pixel stepping.
`timescale 1ns / 1ps
module wctm_datapath #(
  parameter int SCREEN_ROWS     = wctm_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_COLUMNS = wctm_pkg::TEXTURE_COLUMNS_DEF,
  parameter int TEXTURE_ROWS    = wctm_pkg::TEXTURE_ROWS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wctm_pkg::wctm_cmd_t           cmd,
  input  logic [wctm_pkg::COL_W-1:0]    column,
  input  logic                          hit_side,
  input  logic [wctm_pkg::DIST_W-1:0]   wall_distance,
  input  logic signed [wctm_pkg::DIR_W-1:0] dir_x,
  input  logic signed [wctm_pkg::DIR_W-1:0] dir_y,
  input  logic [wctm_pkg::POS_W-1:0]    pos_x,
  input  logic [wctm_pkg::POS_W-1:0]    pos_y,
  output wctm_pkg::wctm_sts_t           sts,
  output wctm_pkg::wctm_result_t        res
);

  localparam int OW_ROW = wctm_pkg::ROW_W;
  localparam int OW_TEX = wctm_pkg::TEX_W;
  localparam int CW     = wctm_pkg::COL_W;
  localparam int DSW    = wctm_pkg::DIST_W;
  localparam int DRW    = wctm_pkg::DIR_W;
  localparam int PSW    = wctm_pkg::POS_W;

  localparam int HW   = $clog2(SCREEN_ROWS + 1) + 16;
  localparam int IW   = $clog2(TEXTURE_ROWS + 1) + 16;
  localparam int DW0  = (HW > IW) ? HW : IW;
  localparam int DW   = (DW0 > DSW) ? DW0 : DSW;
  localparam int RW   = $clog2(SCREEN_ROWS);
  localparam int TCW  = $clog2(TEXTURE_COLUMNS);
  localparam int TCVW = $clog2(TEXTURE_COLUMNS + 1);

  localparam logic [HW-1:0]   H_FULL   = HW'(SCREEN_ROWS * 65536);
  localparam logic [HW-1:0]   H_ONE    = HW'(1);
  localparam logic [HW-1:0]   H_HALF   = HW'(SCREEN_ROWS / 2);
  localparam logic [HW-1:0]   H_ROWS   = HW'(SCREEN_ROWS);
  localparam logic [HW-1:0]   H_LAST   = HW'(SCREEN_ROWS - 1);
  localparam logic [IW-1:0]   INC_NUM  = IW'(TEXTURE_ROWS * 65536);
  localparam logic [TCVW-1:0] TC_MUL   = TCVW'(TEXTURE_COLUMNS);
  localparam logic [TCW-1:0]  TC_LAST  = TCW'(TEXTURE_COLUMNS - 1);
  localparam logic [15:0]     TR_MASK  = 16'(TEXTURE_ROWS - 1);

  // Latched setup request
  logic [CW-1:0]         col_in_r;
  logic                  side_r;
  logic [DSW-1:0]        dist_r;
  logic signed [DRW-1:0] dx_r, dy_r;
  logic [PSW-1:0]        px_r, py_r;

  // Setup pipeline
  logic [HW-1:0]         h_r, offset_r;
  logic [RW-1:0]         top_r, bot_r;
  logic [31+TCVW:0]      tc_prod_r;

  // Slice state
  logic [CW-1:0]         cur_col_r;
  logic [RW-1:0]         cur_row_r, end_row_r, span_top_r;
  logic [TCW-1:0]        tex_col_r;
  logic [31:0]           tex_pos_r;
  logic [IW-1:0]         inc_r;
  logic                  active_r;

  wctm_pkg::wctm_result_t res_r;

  // Divider
  logic [DW-1:0] div_num, div_den, div_q;
  logic          div_done;

  assign div_num = (cmd.div_sel == wctm_pkg::DIV_HEIGHT) ? DW'(H_FULL) : DW'(INC_NUM);
  assign div_den = (cmd.div_sel == wctm_pkg::DIV_HEIGHT) ? DW'(dist_r) : DW'(h_r);

  wctm_divider #(.W(DW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_num),
    .divisor  (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  assign sts.div_done = div_done;

  // Wall-hit coordinate: only the low 32 bits (the fraction) matter
  logic signed [DRW-1:0]    d_sel;
  logic [PSW-1:0]           p_sel;
  logic signed [DSW+DRW:0]  hit_prod;
  logic [31:0]              frac;
  logic [31+TCVW:0]         tc_prod;

  assign d_sel    = side_r ? dx_r : dy_r;
  assign p_sel    = side_r ? px_r : py_r;
  assign hit_prod = $signed({1'b0, dist_r}) * d_sel;
  assign frac     = {p_sel[15:0], 16'h0000} + hit_prod[31:0];
  assign tc_prod  = frac * TC_MUL;

  // Span from height
  logic [HW-1:0] half_h, bot_sum, top_w, bot_w, off_w;

  assign half_h  = h_r >> 1;
  assign bot_sum = H_HALF + half_h;
  assign top_w   = (half_h >= H_HALF) ? '0 : H_HALF - half_h;
  assign bot_w   = (bot_sum >= H_ROWS) ? H_LAST : bot_sum;
  assign off_w   = (half_h > H_HALF) ? half_h - H_HALF : '0;

  // Commit values
  logic [TCW-1:0]      tc_raw, tc_fin;
  logic                mirror;
  logic [HW+IW-1:0]    pos_prod;

  assign tc_raw   = tc_prod_r[32 +: TCW];
  assign mirror   = (!side_r && !dx_r[DRW-1] && (dx_r != '0)) || (side_r && dy_r[DRW-1]);
  assign tc_fin   = mirror ? TC_LAST - tc_raw : tc_raw;
  assign pos_prod = offset_r * inc_r;

  // Pixel step
  logic        last_w;
  logic [15:0] tr_w;

  assign last_w = cur_row_r >= end_row_r;
  assign tr_w   = tex_pos_r[31:16] & TR_MASK;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      col_in_r <= column;
      side_r   <= hit_side;
      dist_r   <= wall_distance;
      dx_r     <= dir_x;
      dy_r     <= dir_y;
      px_r     <= pos_x;
      py_r     <= pos_y;
    end
    if (cmd.h_load) begin
      priority if (dist_r == '0) begin
        h_r <= H_FULL;
      end else if (div_q == '0) begin
        h_r <= H_ONE;
      end else begin
        h_r <= div_q[HW-1:0];
      end
    end
    if (cmd.span) begin
      top_r     <= RW'(top_w);
      bot_r     <= RW'(bot_w);
      offset_r  <= off_w;
      tc_prod_r <= tc_prod;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r  <= '0;
      cur_row_r  <= '0;
      end_row_r  <= '0;
      span_top_r <= '0;
      tex_col_r  <= '0;
      tex_pos_r  <= '0;
      inc_r      <= '0;
      active_r   <= 1'b0;
    end else begin
      if (cmd.inc_load) begin
        inc_r <= div_q[IW-1:0];
      end
      if (cmd.commit) begin
        cur_col_r  <= col_in_r;
        cur_row_r  <= top_r;
        end_row_r  <= bot_r;
        span_top_r <= top_r;
        tex_col_r  <= tc_fin;
        tex_pos_r  <= pos_prod[31:0];
        active_r   <= 1'b1;
      end else if (cmd.step && active_r) begin
        cur_row_r <= cur_row_r + 1'b1;
        tex_pos_r <= tex_pos_r + 32'(inc_r);
        if (last_w) begin
          active_r <= 1'b0;
        end
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_r.kind        <= wctm_pkg::KIND_SETUP;
      res_r.column      <= col_in_r;
      res_r.row         <= '0;
      res_r.tex_col     <= OW_TEX'(tc_fin);
      res_r.tex_row     <= '0;
      res_r.span_top    <= OW_ROW'(top_r);
      res_r.span_bottom <= OW_ROW'(bot_r);
      res_r.last        <= 1'b0;
    end else if (cmd.step) begin
      res_r.column      <= cur_col_r;
      res_r.tex_col     <= OW_TEX'(tex_col_r);
      res_r.span_top    <= OW_ROW'(span_top_r);
      res_r.span_bottom <= OW_ROW'(end_row_r);
      if (active_r) begin
        res_r.kind    <= wctm_pkg::KIND_PIXEL;
        res_r.row     <= OW_ROW'(cur_row_r);
        res_r.tex_row <= OW_TEX'(tr_w);
        res_r.last    <= last_w;
      end else begin
        res_r.kind    <= wctm_pkg::KIND_IDLE;
        res_r.row     <= '0;
        res_r.tex_row <= '0;
        res_r.last    <= 1'b0;
      end
    end
  end

  assign res = res_r;

endmodule

[src/wctm_ctrl.sv]
// Controller: request handshake, setup sequencing and output valid.
`timescale 1ns / 1ps
module wctm_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_func,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  wctm_pkg::wctm_sts_t sts,
  output wctm_pkg::wctm_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_H,
    S_WAIT_H,
    S_SPAN,
    S_DIV_I,
    S_WAIT_I,
    S_COMMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.div_sel   = wctm_pkg::DIV_HEIGHT;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == wctm_pkg::FUNC_SETUP) begin
            cmd.load  = 1'b1;
            state_nxt = S_DIV_H;
          end else begin
            cmd.step      = 1'b1;
            out_valid_nxt = 1'b1;
          end
        end
      end
      S_DIV_H: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_WAIT_H;
      end
      S_WAIT_H: begin
        if (sts.div_done) begin
          cmd.h_load = 1'b1;
          state_nxt  = S_SPAN;
        end
      end
      S_SPAN: begin
        cmd.span  = 1'b1;
        state_nxt = S_DIV_I;
      end
      S_DIV_I: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = wctm_pkg::DIV_INCR;
        state_nxt     = S_WAIT_I;
      end
      S_WAIT_I: begin
        if (sts.div_done) begin
          cmd.inc_load = 1'b1;
          state_nxt    = S_COMMIT;
        end
      end
      S_COMMIT: begin
        // output register is free here: nothing was loaded since the request
        cmd.commit    = 1'b1;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[src/wall_column_texture_mapper.sv]
// Top level of the wall column texture mapper.
`timescale 1ns / 1ps
`include "wall_column_texture_mapper_assert.svh"
// Raycaster wall-slice generator. A setup request (in_tuser = 0) takes the
// column, perpendicular distance, hit side, ray direction and position, and
// returns one setup result with the clamped span and texture column, computed
// with the shared bit-serial divider, run once for the slice height and once for
// the texture step. A step request (in_tuser = 1) returns the next pixel's row
// and texture row, with tlast on the slice's final row, or kind 2 when no slice
// is pending. Steps are taken one per cycle while the output register drains;
// a setup blocks new requests until its result is loaded. A setup during a
// pending slice drops the old slice.
module wall_column_texture_mapper #(
  parameter int SCREEN_ROWS     = wctm_pkg::SCREEN_ROWS_DEF,
  parameter int TEXTURE_COLUMNS = wctm_pkg::TEXTURE_COLUMNS_DEF,
  parameter int TEXTURE_ROWS    = wctm_pkg::TEXTURE_ROWS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // column[9:0], hit_side[10], wall_distance[34:11], dir_x[52:35],
  // dir_y[70:53], pos_x[94:71], pos_y[118:95], zero [119]
  input  logic [wctm_pkg::IN_DATA_W-1:0]    in_tdata,
  // func[0]
  input  logic [0:0]                        in_tuser,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // out_column[9:0], row[18:10], tex_col[24:19], tex_row[30:25],
  // span_top[39:31], span_bottom[48:40], zero [55:49]
  output logic [wctm_pkg::OUT_DATA_W-1:0]   out_tdata,
  // kind[1:0]
  output logic [1:0]                        out_tuser,
  output logic                              out_tlast
);

  wctm_pkg::wctm_cmd_t    cmd;
  wctm_pkg::wctm_sts_t    sts;
  wctm_pkg::wctm_result_t res;

  wctm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_func   (in_tuser[0]),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  wctm_datapath #(
    .SCREEN_ROWS     (SCREEN_ROWS),
    .TEXTURE_COLUMNS (TEXTURE_COLUMNS),
    .TEXTURE_ROWS    (TEXTURE_ROWS)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .column        (in_tdata[9:0]),
    .hit_side      (in_tdata[10]),
    .wall_distance (in_tdata[34:11]),
    .dir_x         (in_tdata[52:35]),
    .dir_y         (in_tdata[70:53]),
    .pos_x         (in_tdata[94:71]),
    .pos_y         (in_tdata[118:95]),
    .sts           (sts),
    .res           (res)
  );

  assign out_tdata = {7'b0000000, res.span_bottom, res.span_top, res.tex_row,
                      res.tex_col, res.row, res.column};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

  // A setup request keeps the input closed in the following cycle
  `WCTM_ASSERT_NXT(a_setup_blocks, in_tvalid && in_tready && (in_tuser[0] == wctm_pkg::FUNC_SETUP), !in_tready)
  // An emitted pixel lies inside its clamped span
  `WCTM_ASSERT_IMP(a_pixel_in_span, out_tvalid && (res.kind == wctm_pkg::KIND_PIXEL), (res.row >= res.span_top) && (res.row <= res.span_bottom))
  // Non-pixel results carry no row, texture row or last mark
  `WCTM_ASSERT_IMP(a_nonpixel_clear, out_tvalid && (res.kind != wctm_pkg::KIND_PIXEL), (res.row == '0) && (res.tex_row == '0) && !res.last)

endmodule

[dv/wall_column_texture_mapper_test.sv]
// Self-checking stream testbench of the wall column texture mapper.
`timescale 1ns / 1ps
module wall_column_texture_mapper_test;

  localparam int ROWS  = wctm_pkg::SCREEN_ROWS_DEF;
  localparam int TCOLS = wctm_pkg::TEXTURE_COLUMNS_DEF;
  localparam int TROWS = wctm_pkg::TEXTURE_ROWS_DEF;
  localparam int CW    = wctm_pkg::COL_W;
  localparam int DSW   = wctm_pkg::DIST_W;
  localparam int DRW   = wctm_pkg::DIR_W;
  localparam int PSW   = wctm_pkg::POS_W;
  localparam int RW    = wctm_pkg::ROW_W;
  localparam int TW    = wctm_pkg::TEX_W;
  localparam int IDW   = wctm_pkg::IN_DATA_W;
  localparam int ODW   = wctm_pkg::OUT_DATA_W;
  localparam int RANDOM_REQS = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 40;

  typedef struct {
    logic           func;
    logic [CW-1:0]  column;
    logic           hit_side;
    logic [DSW-1:0] wall_dist;
    logic [DRW-1:0] dir_x;
    logic [DRW-1:0] dir_y;
    logic [PSW-1:0] pos_x;
    logic [PSW-1:0] pos_y;
  } wall_req_t;

  typedef struct {
    logic [CW-1:0] column;
    logic [RW-1:0] top;
    logic [RW-1:0] bottom;
    logic [TW-1:0] tex_col;
    logic [31:0]   tex_pos;
    logic [31:0]   tex_inc;
  } slice_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_tvalid = 1'b0;
  logic           in_tready;
  logic [IDW-1:0] in_tdata = '0;
  logic [0:0]     in_tuser = '0;
  logic           out_tvalid;
  logic           out_tready = 1'b0;
  logic [ODW-1:0] out_tdata;
  logic [1:0]     out_tuser;
  logic           out_tlast;

  wall_req_t    pending_reqs[$];
  wall_req_t    offered;
  wctm_pkg::wctm_result_t due_results[$];
  slice_t       cur_slice = '{default: '0};
  logic [RW-1:0] next_row = '0;
  logic [31:0]  tex_acc = '0;
  bit           slice_open = 1'b0;

  bit req_taken, res_taken;
  bit send_calm, recv_calm, hold_off;
  int send_gap, recv_gap;
  int reqs_total, reqs_accepted, results_seen, errors;
  int n_setups, n_pixels, n_idle;
  string field_name[8] = '{"kind", "column", "row", "tex_col", "tex_row",
                           "span_top", "span_bottom", "last"};

  wall_column_texture_mapper i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Slice geometry and texture mapping of one column setup
  function automatic slice_t plan_slice(wall_req_t r);
    longint unsigned full_h, h, frac, tc;
    longint half_h, top, bottom, offset, hit;
    slice_t s;
    full_h = longint'(ROWS) << 16;
    h = (r.wall_dist == 0) ? full_h : full_h / r.wall_dist;
    if (h < 1) h = 1;
    half_h = longint'(h / 2);
    top = ROWS / 2 - half_h;
    bottom = ROWS / 2 + half_h;
    if (top < 0) top = 0;
    if (bottom >= ROWS) bottom = ROWS - 1;
    if (r.hit_side == 1'b0)
      hit = (longint'(r.pos_y) << 16) + longint'(r.wall_dist) * longint'($signed(r.dir_y));
    else
      hit = (longint'(r.pos_x) << 16) + longint'(r.wall_dist) * longint'($signed(r.dir_x));
    frac = longint'(hit[31:0]);
    tc = (frac * TCOLS) >> 32;
    // mirror so the texture reads the same way from both sides of the wall
    if ((r.hit_side == 1'b0 && $signed(r.dir_x) > 0) ||
        (r.hit_side == 1'b1 && $signed(r.dir_y) < 0))
      tc = TCOLS - 1 - tc;
    s.column = r.column;
    s.top = RW'(top);
    s.bottom = RW'(bottom);
    s.tex_col = TW'(tc);
    s.tex_inc = 32'((longint'(TROWS) << 16) / h);
    offset = top - ROWS / 2 + half_h;
    s.tex_pos = 32'(offset * longint'(s.tex_inc));
    return s;
  endfunction

  function automatic int pick_gap(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  function automatic wall_req_t random_req(logic func);
    wall_req_t r;
    r.func = func;
    r.column = CW'($urandom);
    r.hit_side = 1'($urandom);
    case ($urandom_range(0, 19))
      0: r.wall_dist = DSW'($urandom_range(0, 3));
      1, 2: r.wall_dist = DSW'($urandom_range(24'h01_0000, 24'h0F_FFFF));
      default: r.wall_dist = DSW'($urandom_range(24'h10_0000, 24'hFF_FFFF));
    endcase
    r.dir_x = DRW'($urandom);
    r.dir_y = DRW'($urandom);
    r.pos_x = PSW'($urandom);
    r.pos_y = PSW'($urandom);
    return r;
  endfunction

  task automatic queue_setup(input logic [CW-1:0] col, input logic side,
                             input logic [DSW-1:0] wdist,
                             input logic [DRW-1:0] dx, input logic [DRW-1:0] dy,
                             input logic [PSW-1:0] px, input logic [PSW-1:0] py);
    pending_reqs.push_back('{wctm_pkg::FUNC_SETUP, col, side, wdist, dx, dy, px, py});
  endtask

  task automatic queue_steps(input int n);
    for (int i = 0; i < n; i++) pending_reqs.push_back(random_req(wctm_pkg::FUNC_STEP));
  endtask

  // Sender: present requests from the queue, with a random gap before each
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_tvalid || req_taken) begin
        if (send_gap > 0) begin
          in_tvalid <= 1'b0;
          send_gap--;
        end else if (pending_reqs.size() > 0) begin
          offered = pending_reqs.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= offered.func;
          in_tdata <= {1'b0, offered.pos_y, offered.pos_x, offered.dir_y, offered.dir_x,
                       offered.wall_dist, offered.hit_side, offered.column};
          send_gap = pick_gap(send_calm);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall for a random gap after each result
  always @(negedge clk) begin
    if (rst_n) begin
      if (res_taken) recv_gap = pick_gap(recv_calm);
      if (hold_off || recv_gap > 0) begin
        out_tready <= 1'b0;
        if (!hold_off) recv_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Hold off the receiver long enough for the block to back up onto its input
  initial begin
    wait (results_seen >= 300);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    wctm_pkg::wctm_result_t want;
    logic [31:0] want_f[8], got_f[8];
    bit at_end;
    req_taken = rst_n && in_tvalid && in_tready;
    res_taken = rst_n && out_tvalid && out_tready;
    if (res_taken) begin
      results_seen++;
      if (due_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: result with nothing expected, got kind %0d data %h", $time,
                   out_tuser, out_tdata);
      end else begin
        want = due_results.pop_front();
        want_f = '{want.kind, want.column, want.row, want.tex_col, want.tex_row,
                   want.span_top, want.span_bottom, want.last};
        got_f = '{out_tuser, out_tdata[9:0], out_tdata[18:10], out_tdata[24:19],
                  out_tdata[30:25], out_tdata[39:31], out_tdata[48:40], out_tlast};
        for (int i = 0; i < 8; i++) begin
          if (want_f[i] !== got_f[i]) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("%0t: %s expected %0d got %0d", $time, field_name[i], want_f[i],
                       got_f[i]);
          end
        end
      end
    end
    if (req_taken) begin
      reqs_accepted++;
      if (offered.func == wctm_pkg::FUNC_SETUP) begin
        // a new setup drops whatever is left of the previous slice
        cur_slice = plan_slice(offered);
        next_row = cur_slice.top;
        tex_acc = cur_slice.tex_pos;
        slice_open = 1'b1;
        want = '{kind: wctm_pkg::KIND_SETUP, column: cur_slice.column,
                 tex_col: cur_slice.tex_col, span_top: cur_slice.top,
                 span_bottom: cur_slice.bottom, default: '0};
        n_setups++;
      end else if (!slice_open) begin
        want = '{kind: wctm_pkg::KIND_IDLE, column: cur_slice.column,
                 tex_col: cur_slice.tex_col, span_top: cur_slice.top,
                 span_bottom: cur_slice.bottom, default: '0};
        n_idle++;
      end else begin
        at_end = next_row >= cur_slice.bottom;
        want = '{kind: wctm_pkg::KIND_PIXEL, column: cur_slice.column, row: next_row,
                 tex_col: cur_slice.tex_col,
                 tex_row: TW'((tex_acc >> 16) & (TROWS - 1)),
                 span_top: cur_slice.top, span_bottom: cur_slice.bottom, last: at_end};
        tex_acc += cur_slice.tex_inc;
        next_row++;
        if (at_end) slice_open = 1'b0;
        n_pixels++;
      end
      due_results.push_back(want);
    end
  end

  initial begin
    wall_req_t r;
    slice_t s;
    int rows, n;

    // Directed: idle step after reset, zero and maximum distance, mirroring on
    // both sides, a negative hit coordinate, a dropped slice, steps past the end
    queue_steps(1);
    queue_setup(10'd0, 1'b0, 24'h0, 18'h0, 18'h0, 24'h0, 24'h0);
    queue_steps(2);
    queue_setup(10'd1023, 1'b1, 24'hFF_FFFF, 18'h1_FFFF, 18'h2_0000, 24'hFF_FFFF,
                24'hFF_FFFF);
    queue_steps(2);
    queue_setup(10'd5, 1'b0, 24'h01_0000, 18'h0_0001, 18'h3_FFFF, 24'h0, 24'h0);
    queue_steps(3);
    queue_setup(10'd639, 1'b1, 24'h08_0000, 18'h2_0000, 18'h1_FFFF, 24'h12_3456, 24'h0);
    queue_steps(3);
    queue_setup(10'd77, 1'b0, 24'h00_0001, 18'h2_0000, 18'h2_0000, 24'hAB_CDEF, 24'h0);
    queue_steps(1);
    queue_setup(10'd320, 1'b1, 24'h60_0000, 18'h0_4000, 18'h0, 24'h0A_8000, 24'h33_0000);
    queue_steps(6);

    // Random: mostly whole slices, some cut short or overrun, some noise
    n = pending_reqs.size() + RANDOM_REQS;
    while (pending_reqs.size() < n) begin
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 8)) pending_reqs.push_back(random_req(1'($urandom_range(0, 1))));
      end else begin
        r = random_req(wctm_pkg::FUNC_SETUP);
        s = plan_slice(r);
        rows = s.bottom - s.top + 1;
        pending_reqs.push_back(r);
        if (rows > 64 && $urandom_range(0, 3) != 0) begin
          queue_steps($urandom_range(1, 16));
        end else begin
          case ($urandom_range(0, 9))
            0: queue_steps(rows + $urandom_range(1, 3));
            1: queue_steps($urandom_range(0, rows));
            default: queue_steps(rows);
          endcase
        end
      end
    end
    reqs_total = pending_reqs.size();

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (reqs_accepted < reqs_total || due_results.size() != 0) @(posedge clk);
    repeat (64) @(posedge clk);

    $display("Checked %0d results from %0d requests: %0d column setups, %0d pixels,",
             results_seen, reqs_accepted, n_setups, n_pixels);
    $display("%0d steps with no slice pending, %0d mismatches", n_idle, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("simulation failed");
    $finish;
  end

endmodule
